>>> src/circle_pair_collision_resolve_core_defines.svh
// Assertion macros shared by the circle pair collision resolve core.
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CPCR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define CPCR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/cpcr_pkg.sv
package cpcr_pkg;

   localparam int POS_W      = 32;
   localparam int RAD_W      = 31;
   localparam int DAMP_W     = 17;
   localparam int DAMP_FRAC  = 16;
   localparam int ROOT_STEPS = 32;
   localparam int QUO_STEPS  = 32;
   localparam int CSR_AW     = 2;

   localparam logic [DAMP_W-1:0] DAMP_ONE   = 17'd65536;
   localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd64881;
   localparam logic [CSR_AW-1:0] CSR_ADDR_DAMPING = 2'd0;

   typedef struct packed {
      logic signed [POS_W-1:0] a_cur_x;
      logic signed [POS_W-1:0] a_cur_y;
      logic signed [POS_W-1:0] a_prev_x;
      logic signed [POS_W-1:0] a_prev_y;
      logic        [RAD_W-1:0] a_radius;
      logic signed [POS_W-1:0] b_cur_x;
      logic signed [POS_W-1:0] b_cur_y;
      logic signed [POS_W-1:0] b_prev_x;
      logic signed [POS_W-1:0] b_prev_y;
      logic        [RAD_W-1:0] b_radius;
   } req_type;

   // Sideband carried alongside the root and divide pipelines.
   typedef struct packed {
      logic signed [POS_W-1:0] acx;
      logic signed [POS_W-1:0] acy;
      logic signed [POS_W-1:0] apx;
      logic signed [POS_W-1:0] apy;
      logic signed [POS_W-1:0] bcx;
      logic signed [POS_W-1:0] bcy;
      logic signed [POS_W-1:0] bpx;
      logic signed [POS_W-1:0] bpy;
      logic                    dx_neg;
      logic                    dy_neg;
      logic        [31:0]      ux;
      logic        [31:0]      uy;
      logic        [31:0]      rs;
      logic                    hit;
   } side_type;

   typedef struct packed {
      logic signed [POS_W-1:0] a_new_cur_x;
      logic signed [POS_W-1:0] a_new_cur_y;
      logic signed [POS_W-1:0] a_new_prev_x;
      logic signed [POS_W-1:0] a_new_prev_y;
      logic signed [POS_W-1:0] b_new_cur_x;
      logic signed [POS_W-1:0] b_new_cur_y;
      logic signed [POS_W-1:0] b_new_prev_x;
      logic signed [POS_W-1:0] b_new_prev_y;
      logic                    collided;
   } rsp_type;

   // Clamp a 36-bit two's complement value to the signed 32-bit range.
   function automatic logic [POS_W-1:0] sat32(input logic [35:0] v);
      logic [POS_W-1:0] r;
      if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
         r = v[31:0];
      end else if (v[35]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

>>> src/cpcr_front.sv
module cpcr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  cpcr_pkg::req_type  in_req,
   output logic               out_valid,
   output cpcr_pkg::side_type out_side,
   output logic [63:0]        out_sq
);

   logic signed [32:0] dx_c, dy_c;
   logic [32:0]        ux_c, uy_c;
   logic [31:0]        rs_c;
   cpcr_pkg::side_type side1_in;
   cpcr_pkg::side_type side3_in;

   logic               v1_ff, v2_ff, v3_ff;
   cpcr_pkg::side_type side1_ff, side2_ff, side3_ff;
   logic [63:0]        sx2_ff, sy2_ff, r2_ff, sq3_ff;
   logic [64:0]        sum_c;
   logic               hit_c;

   always_comb begin
      dx_c = {in_req.a_cur_x[31], in_req.a_cur_x} - {in_req.b_cur_x[31], in_req.b_cur_x};
      dy_c = {in_req.a_cur_y[31], in_req.a_cur_y} - {in_req.b_cur_y[31], in_req.b_cur_y};
      ux_c = dx_c[32] ? (~dx_c + 33'd1) : dx_c;
      uy_c = dy_c[32] ? (~dy_c + 33'd1) : dy_c;
      rs_c = {1'b0, in_req.a_radius} + {1'b0, in_req.b_radius};
      side1_in.acx    = in_req.a_cur_x;
      side1_in.acy    = in_req.a_cur_y;
      side1_in.apx    = in_req.a_prev_x;
      side1_in.apy    = in_req.a_prev_y;
      side1_in.bcx    = in_req.b_cur_x;
      side1_in.bcy    = in_req.b_cur_y;
      side1_in.bpx    = in_req.b_prev_x;
      side1_in.bpy    = in_req.b_prev_y;
      side1_in.dx_neg = dx_c[32];
      side1_in.dy_neg = dy_c[32];
      side1_in.ux     = ux_c[31:0];
      side1_in.uy     = uy_c[31:0];
      side1_in.rs     = rs_c;
      // Both offsets below the radius sum keep the squares within 64 bits.
      side1_in.hit    = (ux_c < {1'b0, rs_c}) && (uy_c < {1'b0, rs_c});
   end

   always_comb begin
      sum_c = {1'b0, sx2_ff} + {1'b0, sy2_ff};
      hit_c = side2_ff.hit && (sum_c != 65'd0) && (sum_c < {1'b0, r2_ff});
      side3_in     = side2_ff;
      side3_in.hit = hit_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff     <= side1_in;
         side2_ff     <= side1_ff;
         sx2_ff       <= 64'(side1_ff.ux) * 64'(side1_ff.ux);
         sy2_ff       <= 64'(side1_ff.uy) * 64'(side1_ff.uy);
         r2_ff        <= 64'(side1_ff.rs) * 64'(side1_ff.rs);
         side3_ff     <= side3_in;
         sq3_ff       <= sum_c[63:0];
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = side3_ff;
   assign out_sq    = sq3_ff;

endmodule

>>> src/cpcr_isqrt.sv
module cpcr_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  cpcr_pkg::side_type in_side,
   input  logic [63:0]        in_sq,
   output logic               out_valid,
   output cpcr_pkg::side_type out_side,
   output logic [31:0]        out_root
);

   localparam int N = cpcr_pkg::ROOT_STEPS;

   logic               v_ff    [N];
   cpcr_pkg::side_type side_ff [N];
   logic [33:0]        rem_ff  [N];
   logic [31:0]        root_ff [N];
   logic [63:0]        rad_ff  [N];

   logic               v_prev    [N];
   cpcr_pkg::side_type side_prev [N];
   logic [33:0]        rem_prev  [N];
   logic [31:0]        root_prev [N];
   logic [63:0]        rad_prev  [N];
   logic [33:0]        rem_in    [N];
   logic [31:0]        root_in   [N];
   logic [63:0]        rad_in    [N];

   // One result bit per stage, classic digit-by-digit square root.
   always_comb begin
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic        ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            v_prev[k]    = in_valid;
            side_prev[k] = in_side;
            rem_prev[k]  = '0;
            root_prev[k] = '0;
            rad_prev[k]  = in_sq;
         end else begin
            v_prev[k]    = v_ff[k-1];
            side_prev[k] = side_ff[k-1];
            rem_prev[k]  = rem_ff[k-1];
            root_prev[k] = root_ff[k-1];
            rad_prev[k]  = rad_ff[k-1];
         end
         rem_sh     = {rem_prev[k], rad_prev[k][63:62]};
         trial      = {2'b00, root_prev[k], 2'b01};
         ge         = (rem_sh >= trial);
         rem_in[k]  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
         root_in[k] = {root_prev[k][30:0], ge};
         rad_in[k]  = {rad_prev[k][61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= v_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            side_ff[k] <= side_prev[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

>>> src/cpcr_divide.sv
module cpcr_divide (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  cpcr_pkg::side_type in_side,
   input  logic [31:0]        in_root,
   output logic               out_valid,
   output cpcr_pkg::side_type out_side,
   output logic [31:0]        out_qx,
   output logic [31:0]        out_qy
);

   localparam int N = cpcr_pkg::QUO_STEPS;

   // Setup: penetration, then |d| * pen, then rounding term and divisor.
   logic               p1_v_ff, p2_v_ff, p3_v_ff;
   cpcr_pkg::side_type p1_side_ff, p2_side_ff, p3_side_ff;
   logic [31:0]        p1_dist_ff, p1_pen_ff, p2_dist_ff;
   logic [63:0]        p2_px_ff, p2_py_ff;
   logic [64:0]        p3_nx_ff, p3_ny_ff;
   logic [32:0]        p3_div_ff;

   logic               v_ff    [N];
   cpcr_pkg::side_type side_ff [N];
   logic [32:0]        div_ff  [N];
   logic [32:0]        rem_ff  [N][2];
   logic [31:0]        low_ff  [N][2];
   logic [31:0]        quo_ff  [N][2];

   logic               v_prev    [N];
   cpcr_pkg::side_type side_prev [N];
   logic [32:0]        div_prev  [N];
   logic [32:0]        rem_prev  [N][2];
   logic [31:0]        low_prev  [N][2];
   logic [31:0]        quo_prev  [N][2];
   logic [32:0]        rem_in    [N][2];
   logic [31:0]        low_in    [N][2];
   logic [31:0]        quo_in    [N][2];

   always_comb begin
      logic [33:0] rsh;
      logic        ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            v_prev[k]      = p3_v_ff;
            side_prev[k]   = p3_side_ff;
            div_prev[k]    = p3_div_ff;
            rem_prev[k][0] = p3_nx_ff[64:32];
            rem_prev[k][1] = p3_ny_ff[64:32];
            low_prev[k][0] = p3_nx_ff[31:0];
            low_prev[k][1] = p3_ny_ff[31:0];
            quo_prev[k][0] = '0;
            quo_prev[k][1] = '0;
         end else begin
            v_prev[k]    = v_ff[k-1];
            side_prev[k] = side_ff[k-1];
            div_prev[k]  = div_ff[k-1];
            for (int l = 0; l < 2; l++) begin
               rem_prev[k][l] = rem_ff[k-1][l];
               low_prev[k][l] = low_ff[k-1][l];
               quo_prev[k][l] = quo_ff[k-1][l];
            end
         end
         for (int l = 0; l < 2; l++) begin
            rsh          = {rem_prev[k][l], low_prev[k][l][31]};
            ge           = (rsh >= {1'b0, div_prev[k]});
            rem_in[k][l] = ge ? 33'(rsh - {1'b0, div_prev[k]}) : rsh[32:0];
            low_in[k][l] = {low_prev[k][l][30:0], 1'b0};
            quo_in[k][l] = {quo_prev[k][l][30:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         p1_v_ff <= in_valid;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= v_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= in_side;
         p1_dist_ff <= in_root;
         p1_pen_ff  <= in_side.rs - in_root;
         p2_side_ff <= p1_side_ff;
         p2_dist_ff <= p1_dist_ff;
         p2_px_ff   <= 64'(p1_side_ff.ux) * 64'(p1_pen_ff);
         p2_py_ff   <= 64'(p1_side_ff.uy) * 64'(p1_pen_ff);
         p3_side_ff <= p2_side_ff;
         p3_nx_ff   <= {1'b0, p2_px_ff} + {33'd0, p2_dist_ff};
         p3_ny_ff   <= {1'b0, p2_py_ff} + {33'd0, p2_dist_ff};
         p3_div_ff  <= {p2_dist_ff, 1'b0};
         for (int k = 0; k < N; k++) begin
            side_ff[k] <= side_prev[k];
            div_ff[k]  <= div_prev[k];
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               low_ff[k][l] <= low_in[k][l];
               quo_ff[k][l] <= quo_in[k][l];
            end
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_qx    = quo_ff[N-1][0];
   assign out_qy    = quo_ff[N-1][1];

endmodule

>>> src/cpcr_back.sv
module cpcr_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  cpcr_pkg::side_type                in_side,
   input  logic [31:0]                       in_qx,
   input  logic [31:0]                       in_qy,
   input  logic [cpcr_pkg::DAMP_W-1:0]       damping,
   output logic                              out_valid,
   output cpcr_pkg::rsp_type                 out_rsp
);

   // Lanes: 0 first x, 1 first y, 2 second x, 3 second y.
   logic        b1_v_ff, b2_v_ff, b3_v_ff, b4_v_ff;
   logic        b1_hit_ff, b2_hit_ff, b3_hit_ff;
   logic [31:0] b1_cur_ff [4];
   logic [31:0] b1_prev_ff[4];
   logic [31:0] b2_cur_ff [4];
   logic [31:0] b2_prev_ff[4];
   logic [32:0] b2_mag_ff [4];
   logic        b2_neg_ff [4];
   logic [31:0] b3_cur_ff [4];
   logic [31:0] b3_prev_ff[4];
   logic [49:0] b3_prod_ff[4];
   logic        b3_neg_ff [4];
   cpcr_pkg::rsp_type rsp_ff;

   logic [31:0] cur_c   [4];
   logic [31:0] prev_c  [4];
   logic [32:0] vel_c   [4];
   logic [31:0] nprev_c [4];
   logic signed [32:0] mx_c, my_c;
   logic [35:0] sum_c   [4];

   always_comb begin
      mx_c = in_side.dx_neg ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
      my_c = in_side.dy_neg ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
      prev_c[0] = in_side.apx;
      prev_c[1] = in_side.apy;
      prev_c[2] = in_side.bpx;
      prev_c[3] = in_side.bpy;
      // The first particle moves along the normal, the second against it.
      sum_c[0] = {{4{in_side.acx[31]}}, in_side.acx} + {{3{mx_c[32]}}, mx_c};
      sum_c[1] = {{4{in_side.acy[31]}}, in_side.acy} + {{3{my_c[32]}}, my_c};
      sum_c[2] = {{4{in_side.bcx[31]}}, in_side.bcx} - {{3{mx_c[32]}}, mx_c};
      sum_c[3] = {{4{in_side.bcy[31]}}, in_side.bcy} - {{3{my_c[32]}}, my_c};
      if (in_side.hit) begin
         for (int i = 0; i < 4; i++) begin
            cur_c[i] = cpcr_pkg::sat32(sum_c[i]);
         end
      end else begin
         cur_c[0] = in_side.acx;
         cur_c[1] = in_side.acy;
         cur_c[2] = in_side.bcx;
         cur_c[3] = in_side.bcy;
      end
   end

   always_comb begin
      logic [50:0] rnd;
      logic [34:0] w;
      logic [35:0] ws;
      for (int i = 0; i < 4; i++) begin
         vel_c[i] = {b1_cur_ff[i][31], b1_cur_ff[i]} - {b1_prev_ff[i][31], b1_prev_ff[i]};
         rnd = {1'b0, b3_prod_ff[i]} + (51'd1 << (cpcr_pkg::DAMP_FRAC - 1));
         w   = rnd[cpcr_pkg::DAMP_FRAC +: 35];
         ws  = b3_neg_ff[i] ? (~{1'b0, w} + 36'd1) : {1'b0, w};
         nprev_c[i] = b3_hit_ff
                    ? cpcr_pkg::sat32({{4{b3_cur_ff[i][31]}}, b3_cur_ff[i]} - ws)
                    : b3_prev_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
         b4_v_ff <= 1'b0;
      end else if (en) begin
         b1_v_ff <= in_valid;
         b2_v_ff <= b1_v_ff;
         b3_v_ff <= b2_v_ff;
         b4_v_ff <= b3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_hit_ff <= in_side.hit;
         b2_hit_ff <= b1_hit_ff;
         b3_hit_ff <= b2_hit_ff;
         for (int i = 0; i < 4; i++) begin
            b1_cur_ff[i]  <= cur_c[i];
            b1_prev_ff[i] <= prev_c[i];
            b2_cur_ff[i]  <= b1_cur_ff[i];
            b2_prev_ff[i] <= b1_prev_ff[i];
            b2_neg_ff[i]  <= vel_c[i][32];
            b2_mag_ff[i]  <= vel_c[i][32] ? (~vel_c[i] + 33'd1) : vel_c[i];
            b3_cur_ff[i]  <= b2_cur_ff[i];
            b3_prev_ff[i] <= b2_prev_ff[i];
            b3_neg_ff[i]  <= b2_neg_ff[i];
            b3_prod_ff[i] <= 50'(b2_mag_ff[i]) * 50'(damping);
         end
         rsp_ff.a_new_cur_x  <= b3_cur_ff[0];
         rsp_ff.a_new_cur_y  <= b3_cur_ff[1];
         rsp_ff.b_new_cur_x  <= b3_cur_ff[2];
         rsp_ff.b_new_cur_y  <= b3_cur_ff[3];
         rsp_ff.a_new_prev_x <= nprev_c[0];
         rsp_ff.a_new_prev_y <= nprev_c[1];
         rsp_ff.b_new_prev_x <= nprev_c[2];
         rsp_ff.b_new_prev_y <= nprev_c[3];
         rsp_ff.collided     <= b3_hit_ff;
      end
   end

   assign out_valid = b4_v_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> src/circle_pair_collision_resolve_core.sv
// Circle pair collision resolve core.
// Each request carries two circular particles in Verlet form (current and
// previous position, signed Q16.16, plus radius). When the circles overlap
// and their centres differ, both are pushed apart by half the penetration
// along the normal and their previous positions are rebuilt so that the
// implicit velocity is scaled by the damping register; otherwise every
// field passes through and collided is low.
// The request channel (req_) and result channel (rsp_) use valid/ready.
// The damping register (Q1.16, values above one saturate) sits at byte
// address zero of the APB-style port and must only be written when idle.
// A request passes in order through the squared-distance stages, the
// one-bit-per-stage square root, the setup and one-bit-per-stage divide,
// and the damping stages before rsp_valid rises.
// One request is accepted every cycle while the result side keeps up.
// A stalled result holds the whole pipeline in place, so req_ready drops
// while rsp_valid is high and rsp_ready low; nothing is lost or repeated.
// Reset empties the pipeline and restores damping to 64881 (about 0.99).
`include "circle_pair_collision_resolve_core_defines.svh"

module circle_pair_collision_resolve_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_a_cur_x,
   input  logic signed [31:0]                req_a_cur_y,
   input  logic signed [31:0]                req_a_prev_x,
   input  logic signed [31:0]                req_a_prev_y,
   input  logic        [30:0]                req_a_radius,
   input  logic signed [31:0]                req_b_cur_x,
   input  logic signed [31:0]                req_b_cur_y,
   input  logic signed [31:0]                req_b_prev_x,
   input  logic signed [31:0]                req_b_prev_y,
   input  logic        [30:0]                req_b_radius,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_a_new_cur_x,
   output logic signed [31:0]                rsp_a_new_cur_y,
   output logic signed [31:0]                rsp_a_new_prev_x,
   output logic signed [31:0]                rsp_a_new_prev_y,
   output logic signed [31:0]                rsp_b_new_cur_x,
   output logic signed [31:0]                rsp_b_new_cur_y,
   output logic signed [31:0]                rsp_b_new_prev_x,
   output logic signed [31:0]                rsp_b_new_prev_y,
   output logic                              rsp_collided,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cpcr_pkg::CSR_AW-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [cpcr_pkg::DAMP_W-1:0] damping_ff, damping_in;
   logic                        csr_write;
   logic                        en;

   cpcr_pkg::req_type  req;
   cpcr_pkg::side_type front_side, root_side, div_side;
   cpcr_pkg::rsp_type  rsp;
   logic               front_valid, root_valid, div_valid;
   logic [63:0]        front_sq;
   logic [31:0]        root_dist, div_qx, div_qy;

   // Register port. The write lands on the access phase; pready is tied high.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                    && (paddr == cpcr_pkg::CSR_ADDR_DAMPING);

   always_comb begin
      // A damping factor above one in pwdata[16:0] is clamped to exactly one.
      if (pwdata[cpcr_pkg::DAMP_W-1:0] > cpcr_pkg::DAMP_ONE) begin
         damping_in = cpcr_pkg::DAMP_ONE;
      end else begin
         damping_in = pwdata[cpcr_pkg::DAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= cpcr_pkg::DAMP_RESET;
      end else if (csr_write) begin
         damping_ff <= damping_in;
      end
   end

   always_comb begin
      case (paddr)
         cpcr_pkg::CSR_ADDR_DAMPING: begin
            prdata = 32'(damping_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // The whole pipeline advances together unless the result register is
   // holding a result the receiver has not taken yet.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      req.a_cur_x  = req_a_cur_x;
      req.a_cur_y  = req_a_cur_y;
      req.a_prev_x = req_a_prev_x;
      req.a_prev_y = req_a_prev_y;
      req.a_radius = req_a_radius;
      req.b_cur_x  = req_b_cur_x;
      req.b_cur_y  = req_b_cur_y;
      req.b_prev_x = req_b_prev_x;
      req.b_prev_y = req_b_prev_y;
      req.b_radius = req_b_radius;
   end

   cpcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_sq    (front_sq)
   );

   cpcr_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_sq     (front_sq),
      .out_valid (root_valid),
      .out_side  (root_side),
      .out_root  (root_dist)
   );

   cpcr_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_side   (root_side),
      .in_root   (root_dist),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_qx    (div_qx),
      .out_qy    (div_qy)
   );

   cpcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_side   (div_side),
      .in_qx     (div_qx),
      .in_qy     (div_qy),
      .damping   (damping_ff),
      .out_valid (rsp_valid),
      .out_rsp   (rsp)
   );

   assign rsp_a_new_cur_x  = rsp.a_new_cur_x;
   assign rsp_a_new_cur_y  = rsp.a_new_cur_y;
   assign rsp_a_new_prev_x = rsp.a_new_prev_x;
   assign rsp_a_new_prev_y = rsp.a_new_prev_y;
   assign rsp_b_new_cur_x  = rsp.b_new_cur_x;
   assign rsp_b_new_cur_y  = rsp.b_new_cur_y;
   assign rsp_b_new_prev_x = rsp.b_new_prev_x;
   assign rsp_b_new_prev_y = rsp.b_new_prev_y;
   assign rsp_collided     = rsp.collided;

   // The damping factor never exceeds one, whatever was written.
   `CPCR_ASSERT_ALWAYS(a_damping_bound, clock, reset, damping_ff <= cpcr_pkg::DAMP_ONE, "damping above one")
   // The pipeline comes out of reset empty.
   `CPCR_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid, "result after reset")
   // A stalled result blocks new requests.
   `CPCR_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken in stall")

endmodule

>>> tb/sv/tb.sv
module tb;

   // Longest stretch without any accepted request or result before the run is
   // declared hung. This leaves a wide margin over the long receiver hold-off
   // and over the pipeline, which is 74 deep.
   localparam int HANG_LIMIT = 5000;
   // Cycles to wait after the last expected result before the block is idle.
   localparam int PIPE_DEPTH = 80;

   logic clock;
   logic reset;

   logic req_valid;
   logic req_ready;
   logic signed [31:0] req_a_cur_x, req_a_cur_y, req_a_prev_x, req_a_prev_y;
   logic        [30:0] req_a_radius;
   logic signed [31:0] req_b_cur_x, req_b_cur_y, req_b_prev_x, req_b_prev_y;
   logic        [30:0] req_b_radius;

   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_a_new_cur_x, rsp_a_new_cur_y, rsp_a_new_prev_x, rsp_a_new_prev_y;
   logic signed [31:0] rsp_b_new_cur_x, rsp_b_new_cur_y, rsp_b_new_prev_x, rsp_b_new_prev_y;
   logic rsp_collided;

   logic psel, penable, pwrite;
   logic [cpcr_pkg::CSR_AW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   // The damping value the predictor believes the block holds.
   logic [cpcr_pkg::DAMP_W-1:0] damp_model;

   // Results the block still owes, oldest first.
   cpcr_pkg::rsp_type pending_rsp[$];

   int errors;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_rsp;
   int quiet_cycles;

   circle_pair_collision_resolve_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_cur_x(req_a_cur_x), .req_a_cur_y(req_a_cur_y),
      .req_a_prev_x(req_a_prev_x), .req_a_prev_y(req_a_prev_y),
      .req_a_radius(req_a_radius),
      .req_b_cur_x(req_b_cur_x), .req_b_cur_y(req_b_cur_y),
      .req_b_prev_x(req_b_prev_x), .req_b_prev_y(req_b_prev_y),
      .req_b_radius(req_b_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_a_new_cur_x(rsp_a_new_cur_x), .rsp_a_new_cur_y(rsp_a_new_cur_y),
      .rsp_a_new_prev_x(rsp_a_new_prev_x), .rsp_a_new_prev_y(rsp_a_new_prev_y),
      .rsp_b_new_cur_x(rsp_b_new_cur_x), .rsp_b_new_cur_y(rsp_b_new_cur_y),
      .rsp_b_new_prev_x(rsp_b_new_prev_x), .rsp_b_new_prev_y(rsp_b_new_prev_y),
      .rsp_collided(rsp_collided),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Clamp an exact signed value to the signed 32-bit range.
   function automatic logic [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // Floor of the square root, one result bit per iteration.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Push along one axis: |d| * pen / (2 * dlen), ties up, with the sign of d.
   function automatic logic signed [63:0] push_along(input logic signed [63:0] d,
                                                     input logic [63:0] pen,
                                                     input logic [63:0] dlen);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (d < 0) ? -d : d;
      q = (mag * pen + dlen) / (2 * dlen);
      return (d < 0) ? -$signed(q) : $signed(q);
   endfunction

   // Rebuild a previous position so the implied velocity is scaled by damping.
   // The scaled velocity is rounded to nearest with ties away from zero.
   function automatic logic [31:0] damped_prev(input logic signed [31:0] cur,
                                               input logic signed [31:0] prev);
      logic signed [63:0] vel;
      logic [63:0] mag;
      logic [63:0] scaled;
      logic signed [63:0] ws;
      vel = 64'(cur) - 64'(prev);
      mag = (vel < 0) ? -vel : vel;
      scaled = (mag * 64'(damp_model) + 64'd32768) >> cpcr_pkg::DAMP_FRAC;
      ws = (vel < 0) ? -$signed(scaled) : $signed(scaled);
      return clamp32(64'(cur) - ws);
   endfunction

   // Expected result for one particle pair under the current damping.
   function automatic cpcr_pkg::rsp_type resolve_pair(input cpcr_pkg::req_type r);
      cpcr_pkg::rsp_type o;
      logic signed [63:0] dx, dy, mx, my;
      logic [63:0] ux, uy, rs, r2, dlen, pen;
      logic [64:0] s;
      o.a_new_cur_x  = r.a_cur_x;
      o.a_new_cur_y  = r.a_cur_y;
      o.a_new_prev_x = r.a_prev_x;
      o.a_new_prev_y = r.a_prev_y;
      o.b_new_cur_x  = r.b_cur_x;
      o.b_new_cur_y  = r.b_cur_y;
      o.b_new_prev_x = r.b_prev_x;
      o.b_new_prev_y = r.b_prev_y;
      o.collided     = 1'b0;
      dx = 64'(r.a_cur_x) - 64'(r.b_cur_x);
      dy = 64'(r.a_cur_y) - 64'(r.b_cur_y);
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      rs = 64'(r.a_radius) + 64'(r.b_radius);
      r2 = rs * rs;
      // Each axis must already be inside the summed radius before squaring.
      if (ux < rs && uy < rs) begin
         s = 65'(ux * ux) + 65'(uy * uy);
         if (s != 65'd0 && s < 65'(r2)) begin
            dlen = floor_sqrt(s[63:0]);
            pen = rs - dlen;
            mx = push_along(dx, pen, dlen);
            my = push_along(dy, pen, dlen);
            o.collided = 1'b1;
            o.a_new_cur_x = clamp32(64'(r.a_cur_x) + mx);
            o.a_new_cur_y = clamp32(64'(r.a_cur_y) + my);
            o.b_new_cur_x = clamp32(64'(r.b_cur_x) - mx);
            o.b_new_cur_y = clamp32(64'(r.b_cur_y) - my);
            o.a_new_prev_x = damped_prev(o.a_new_cur_x, r.a_prev_x);
            o.a_new_prev_y = damped_prev(o.a_new_cur_y, r.a_prev_y);
            o.b_new_prev_x = damped_prev(o.b_new_cur_x, r.b_prev_x);
            o.b_new_prev_y = damped_prev(o.b_new_cur_y, r.b_prev_y);
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
      errors++;
   endtask

   // Sends one request and holds it until the block takes it. Must be called
   // right after a rising edge. Each cycle before the request is idle with
   // the sender's idle chance, so that share of cycles carries no request.
   task automatic send_pair(input cpcr_pkg::req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_a_cur_x  <= r.a_cur_x;
      req_a_cur_y  <= r.a_cur_y;
      req_a_prev_x <= r.a_prev_x;
      req_a_prev_y <= r.a_prev_y;
      req_a_radius <= r.a_radius;
      req_b_cur_x  <= r.b_cur_x;
      req_b_cur_y  <= r.b_cur_y;
      req_b_prev_x <= r.b_prev_x;
      req_b_prev_y <= r.b_prev_y;
      req_b_radius <= r.b_radius;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(resolve_pair(r));
   endtask

   // Waits until every owed result has arrived, then for the pipeline depth.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   // Two-phase register write; the block is idle whenever this is called.
   task automatic write_damping(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= cpcr_pkg::CSR_ADDR_DAMPING;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // Values above one in the low 17 bits saturate to exactly one.
      damp_model = (value[16:0] > cpcr_pkg::DAMP_ONE) ? cpcr_pkg::DAMP_ONE : value[16:0];
      @(posedge clock);
   endtask

   // Random particle pair. Most pairs put the centres within the radius sum on each axis so the root,
   // divide and damping stages see real work; the rest are full-width noise.
   task automatic random_pair(output cpcr_pkg::req_type r);
      int unsigned k, kb, sel;
      logic [63:0] rs, off;
      logic [31:0] mask;
      sel = $urandom_range(0, 9);
      r.a_cur_x  = $urandom;
      r.a_cur_y  = $urandom;
      r.a_prev_x = $urandom;
      r.a_prev_y = $urandom;
      r.a_radius = 31'($urandom);
      r.b_cur_x  = $urandom;
      r.b_cur_y  = $urandom;
      r.b_prev_x = $urandom;
      r.b_prev_y = $urandom;
      r.b_radius = 31'($urandom);
      if (sel < 7) begin
         k = $urandom_range(2, 31);
         kb = $urandom_range(2, 31);
         r.a_radius = 31'($urandom & ((32'd1 << k) - 1));
         r.b_radius = 31'($urandom & ((32'd1 << kb) - 1));
         rs = 64'(r.a_radius) + 64'(r.b_radius);
         // Offset of the first centre from the second, inside the radius sum.
         off = ({$urandom, $urandom} % (rs + 1)) * $urandom_range(0, 100) / 100;
         r.a_cur_x = r.b_cur_x + ($urandom_range(0, 1) ? off[31:0] : -off[31:0]);
         off = ({$urandom, $urandom} % (rs + 1)) * $urandom_range(0, 100) / 100;
         r.a_cur_y = r.b_cur_y + ($urandom_range(0, 1) ? off[31:0] : -off[31:0]);
         // Previous positions close to the current ones, as a real step would.
         mask = (32'd1 << $urandom_range(1, 31)) - 1;
         r.a_prev_x = r.a_cur_x + ($signed($urandom & mask) - $signed(mask >> 1));
         r.a_prev_y = r.a_cur_y + ($signed($urandom & mask) - $signed(mask >> 1));
         r.b_prev_x = r.b_cur_x + ($signed($urandom & mask) - $signed(mask >> 1));
         r.b_prev_y = r.b_cur_y + ($signed($urandom & mask) - $signed(mask >> 1));
      end
   endtask

   task automatic run_random(input int count);
      cpcr_pkg::req_type r;
      repeat (count) begin
         random_pair(r);
         send_pair(r);
      end
   endtask

   // Builds a pair from its fields; used by the directed cases only.
   function automatic cpcr_pkg::req_type make_pair(input logic [31:0] acx, acy, apx, apy,
                                                   input logic [30:0] ar,
                                                   input logic [31:0] bcx, bcy, bpx, bpy,
                                                   input logic [30:0] br);
      cpcr_pkg::req_type r;
      r.a_cur_x = acx; r.a_cur_y = acy; r.a_prev_x = apx; r.a_prev_y = apy;
      r.a_radius = ar;
      r.b_cur_x = bcx; r.b_cur_y = bcy; r.b_prev_x = bpx; r.b_prev_y = bpy;
      r.b_radius = br;
      return r;
   endfunction

   // Directed pairs: coincident centres, touching and separated circles,
   // single-axis and diagonal overlap, zero radii, and saturation at the
   // corners of the position range.
   task automatic test_directed();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(32'h10000, 32'h20000, 1, 2, 31'h10000,
                          32'h10000, 32'h20000, 3, 4, 31'h10000));
      send_pair(make_pair(32'h10000, 0, 0, 0, 31'h10000, 0, 0, 0, 0, 31'h10000));
      send_pair(make_pair(32'h20000, 0, 0, 0, 31'h10000, 0, 0, 0, 0, 31'h10000));
      send_pair(make_pair(32'h30000, 0, 0, 0, 31'h10000, 0, 0, 0, 0, 31'h10000));
      send_pair(make_pair(0, 32'h8000, 0, 32'h7000, 31'h10000, 0, 0, 0, 0, 31'h10000));
      send_pair(make_pair(-32'sh8000, -32'sh8000, 0, 0, 31'h10000,
                          32'h8000, 32'h8000, 0, 0, 31'h10000));
      send_pair(make_pair(3, 4, 0, 0, 3, 0, 0, 0, 0, 2));
      send_pair(make_pair(3, 4, 0, 0, 3, 0, 0, 0, 0, 3));
      send_pair(make_pair(1, 0, 5, 5, 0, 0, 0, 0, 0, 2));
      send_pair(make_pair(1, 0, 5, 5, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          31'h7FFF_FFFF, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 0, 0,
                          31'h7FFF_FFFF));
      send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          31'h7FFF_FFFF, 32'h8000_0010, 32'h8000_0000, 32'h7FFF_FFFF,
                          0, 31'h7FFF_FFFF));
      send_pair(make_pair(32'h8000_0000, 0, 0, 0, 31'h7FFF_FFFF,
                          32'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF));
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 31'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF));
      send_pair(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 31'h7FFF_FFFF));
      send_pair(make_pair(32'h1234_5678, 32'h1234_0000, 32'h1000_0000, 32'h1300_0000,
                          31'h0100_0000, 32'h1200_0000, 32'h1200_0000, 32'h1400_0000,
                          32'h1100_0000, 31'h0080_0000));
      drain_pipe();
   endtask

   // Sweeps damping through zero, one, values above one, and the reset
   // value, with random pairs under each setting.
   task automatic test_damping_sweep();
      logic [31:0] settings[7];
      settings = '{32'd0, 32'd1, 32'd65536, 32'd65537, 32'h0001_FFFF,
                   32'hFFFF_8000, 32'd64881};
      foreach (settings[i]) begin
         write_damping(settings[i]);
         run_random(45);
         drain_pipe();
      end
   endtask

   // Random traffic under each idling pattern of sender and receiver.
   task automatic test_idle_patterns();
      int idle_set[4] = '{0, 68, 0, 9};
      int stall_set[4] = '{0, 0, 68, 9};
      for (int i = 0; i < 4; i++) begin
         sender_idle_pct = idle_set[i];
         receiver_stall_pct = stall_set[i];
         write_damping($urandom_range(0, 65536));
         run_random(120);
         drain_pipe();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   // The receiver holds off long enough for the pipeline to fill, so the
   // block has to stall its request side while requests keep coming.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 20;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      run_random(160);
      drain_pipe();
   endtask

   // Receiver side: random stalls, or a solid hold-off while hold_rsp is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      cpcr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("unexpected result at %0t", $time);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_a_new_cur_x !== want.a_new_cur_x)
               report_mismatch("a_new_cur_x", rsp_a_new_cur_x, want.a_new_cur_x);
            if (rsp_a_new_cur_y !== want.a_new_cur_y)
               report_mismatch("a_new_cur_y", rsp_a_new_cur_y, want.a_new_cur_y);
            if (rsp_a_new_prev_x !== want.a_new_prev_x)
               report_mismatch("a_new_prev_x", rsp_a_new_prev_x, want.a_new_prev_x);
            if (rsp_a_new_prev_y !== want.a_new_prev_y)
               report_mismatch("a_new_prev_y", rsp_a_new_prev_y, want.a_new_prev_y);
            if (rsp_b_new_cur_x !== want.b_new_cur_x)
               report_mismatch("b_new_cur_x", rsp_b_new_cur_x, want.b_new_cur_x);
            if (rsp_b_new_cur_y !== want.b_new_cur_y)
               report_mismatch("b_new_cur_y", rsp_b_new_cur_y, want.b_new_cur_y);
            if (rsp_b_new_prev_x !== want.b_new_prev_x)
               report_mismatch("b_new_prev_x", rsp_b_new_prev_x, want.b_new_prev_x);
            if (rsp_b_new_prev_y !== want.b_new_prev_y)
               report_mismatch("b_new_prev_y", rsp_b_new_prev_y, want.b_new_prev_y);
            if (rsp_collided !== want.collided)
               report_mismatch("collided", 32'(rsp_collided), 32'(want.collided));
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a request or result.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAIL circle_pair_collision_resolve_core");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      hold_rsp = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      damp_model = cpcr_pkg::DAMP_RESET;
      quiet_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_a_cur_x, req_a_cur_y, req_a_prev_x, req_a_prev_y} = '0;
      {req_b_cur_x, req_b_cur_y, req_b_prev_x, req_b_prev_y} = '0;
      req_a_radius = '0;
      req_b_radius = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first pairs run with the reset damping value.
      test_directed();
      test_damping_sweep();
      test_idle_patterns();
      test_backpressure();

      if (errors == 0) begin
         $display("PASS circle_pair_collision_resolve_core");
      end else begin
         $display("FAIL circle_pair_collision_resolve_core");
      end
      $finish;
   end

endmodule
